### src/spq_pkg.sv
// shared types and constants for the sorted priority queue
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  typedef enum logic {
    KIND_STORE    = 1'b0,
    KIND_RETRIEVE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [DATA_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    status_t                  status;
  } result_t;

  // entry memory control from the sequencer
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } ram_ctrl_t;

endpackage

### src/sorted_priority_queue_core.sv
// top level of the sorted min-first priority queue
//
// usage:
//   a request (kind, value) is taken at a rising edge with start high and
//   busy low. kind store inserts value in ascending order, ahead of equal
//   values already held; kind retrieve removes the smallest value.
//   every request gives one result (result_value, status) on the result
//   port for exactly one cycle, marked by done. the receiver cannot stall.
// steps:
//   store into full or empty queue, retrieve from empty queue: answered from idle
//   store: scan down from the top, moving each entry >= value one slot up;
//     the scan always ends with one write of the new value
//   retrieve: read the head, then move each remaining entry one slot down
//   done rises the cycle after the last step; busy is low in that cycle,
//   so the next request may be taken alongside the result.
// rate: one entry slot per cycle, set by the single compare/move unit and
//   the one write and one registered read port of the entry memory.
// reset: synchronous; empties the queue and drops any request in flight.
module sorted_priority_queue_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::request_t request,
  output logic              done,
  output spq_pkg::result_t  result
);

  spq_pkg::ram_ctrl_t          ram;
  logic [spq_pkg::DATA_W-1:0]  rdata;

  // sequencer
  spq_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .ram     (ram),
    .rdata   (rdata)
  );

  // entry memory
  spq_ram #(
    .WIDTH (spq_pkg::DATA_W),
    .DEPTH (spq_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .raddr (ram.raddr),
    .rdata (rdata)
  );

  // a result always comes with the block ready again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // an accepted request either gives its result next or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request lost");

  // leaving busy always delivers a result
  a_fell_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("request finished without result");

  // failed requests return zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != spq_pkg::STATUS_OK)) |-> (result.result_value == '0))
    else $error("nonzero value with error status");

endmodule

### src/spq_ram.sv
// generic single write port memory with registered read
module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/spq_seq.sv
// sequencer: walks the sorted entries one slot a cycle through one comparator
module spq_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  spq_pkg::request_t              request,
  output logic                           done,
  output spq_pkg::result_t               result,
  output spq_pkg::ram_ctrl_t             ram,
  input  logic [spq_pkg::DATA_W-1:0]     rdata
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_PLACE = 5'b00100,
    S_HEAD  = 5'b01000,
    S_SHIFT = 5'b10000
  } state_t;

  state_t                          state, state_next;
  logic [spq_pkg::IDX_W-1:0]       idx, idx_next;
  logic [spq_pkg::CNT_W-1:0]       occupancy, occupancy_next;
  logic signed [spq_pkg::DATA_W-1:0] item_value;
  logic                            done_next;
  spq_pkg::result_t                result_next;
  logic                            accept;
  logic                            keep_going;
  logic                            last_shift;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  // single comparator: the held entry stays behind the new value while >= it
  assign keep_going = ($signed(rdata) >= item_value);

  // last slot of the retrieve shift
  assign last_shift = (spq_pkg::CNT_W'(idx) == (occupancy - spq_pkg::CNT_W'(1)));

  // sequencer next state and memory control
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    occupancy_next = occupancy;
    done_next      = 1'b0;
    result_next    = result;
    ram.we         = 1'b0;
    ram.waddr      = idx;
    ram.wdata      = rdata;
    ram.raddr      = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (request.kind == spq_pkg::KIND_STORE) begin
            result_next.result_value = '0;
            if (occupancy == spq_pkg::CNT_FULL) begin
              result_next.status = spq_pkg::STATUS_FULL;
              done_next          = 1'b1;
            end else if (occupancy == '0) begin
              ram.we             = 1'b1;
              ram.waddr          = '0;
              ram.wdata          = request.value;
              occupancy_next     = occupancy + spq_pkg::CNT_W'(1);
              result_next.status = spq_pkg::STATUS_OK;
              done_next          = 1'b1;
            end else begin
              idx_next   = occupancy[spq_pkg::IDX_W-1:0];
              ram.raddr  = occupancy[spq_pkg::IDX_W-1:0] - spq_pkg::IDX_W'(1);
              state_next = S_SCAN;
            end
          end else begin
            if (occupancy == '0) begin
              result_next.result_value = '0;
              result_next.status       = spq_pkg::STATUS_EMPTY;
              done_next                = 1'b1;
            end else begin
              ram.raddr  = '0;
              state_next = S_HEAD;
            end
          end
        end
      end
      S_SCAN: begin
        ram.we = 1'b1;
        if (keep_going) begin
          // move the entry one slot up and look one slot lower
          ram.wdata = rdata;
          if (idx == spq_pkg::IDX_W'(1)) begin
            idx_next   = '0;
            state_next = S_PLACE;
          end else begin
            idx_next  = idx - spq_pkg::IDX_W'(1);
            ram.raddr = idx - spq_pkg::IDX_W'(2);
          end
        end else begin
          ram.wdata          = item_value;
          occupancy_next     = occupancy + spq_pkg::CNT_W'(1);
          result_next.status = spq_pkg::STATUS_OK;
          done_next          = 1'b1;
          state_next         = S_IDLE;
        end
      end
      S_PLACE: begin
        ram.we             = 1'b1;
        ram.waddr          = '0;
        ram.wdata          = item_value;
        occupancy_next     = occupancy + spq_pkg::CNT_W'(1);
        result_next.status = spq_pkg::STATUS_OK;
        done_next          = 1'b1;
        state_next         = S_IDLE;
      end
      S_HEAD: begin
        // smallest entry is out; close the gap if more remain
        result_next.result_value = rdata;
        result_next.status       = spq_pkg::STATUS_OK;
        if (occupancy == spq_pkg::CNT_W'(1)) begin
          occupancy_next = '0;
          done_next      = 1'b1;
          state_next     = S_IDLE;
        end else begin
          idx_next   = spq_pkg::IDX_W'(1);
          ram.raddr  = spq_pkg::IDX_W'(1);
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        ram.we    = 1'b1;
        ram.waddr = idx - spq_pkg::IDX_W'(1);
        ram.wdata = rdata;
        if (last_shift) begin
          occupancy_next = occupancy - spq_pkg::CNT_W'(1);
          done_next      = 1'b1;
          state_next     = S_IDLE;
        end else begin
          idx_next  = idx + spq_pkg::IDX_W'(1);
          ram.raddr = idx + spq_pkg::IDX_W'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occupancy <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      occupancy <= occupancy_next;
      done      <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx    <= idx_next;
    result <= result_next;
    if (accept) begin
      item_value <= request.value;
    end
  end

endmodule
